FILE: design/fair_share_min_runtime_scheduler_macros.svh
// ----------------------------------------------------------------------------
// fair_share_min_runtime_scheduler_macros
// assertion macros used by the top-level scheduler file
// ----------------------------------------------------------------------------
`ifndef FAIR_SHARE_MIN_RUNTIME_SCHEDULER_MACROS_SVH
`define FAIR_SHARE_MIN_RUNTIME_SCHEDULER_MACROS_SVH

// same-cycle implication
`define FSMRS_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("scheduler same-cycle check failed");

// next-cycle implication
`define FSMRS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("scheduler next-cycle check failed");

`endif

FILE: design/fsmrs_pkg.sv
// ----------------------------------------------------------------------------
// fsmrs_pkg
// types and constants of the fair-share minimum-runtime scheduler
// ----------------------------------------------------------------------------
package fsmrs_pkg;

   localparam int SLOTS_DEF    = 32;
   localparam int SLOT_FIELD_W = 5;
   localparam int RUNTIME_W    = 31;
   localparam int TIME_W       = 32;

   localparam logic [RUNTIME_W-1:0] RT_MAX = {RUNTIME_W{1'b1}};

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic                    command;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TIME_W-1:0]       now;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic [RUNTIME_W-1:0]    chosen_runtime;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic cap_req;
      logic rt_rd;
      logic sch_wr;
      logic chg_wr;
      logic scan_issue;
      logic out_rd;
      logic out_rsp;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dispatch;
      logic scan_last;
   } dp_sts_type;

endpackage

FILE: design/fsmrs_ram.sv
// ----------------------------------------------------------------------------
// fsmrs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module fsmrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/fsmrs_ctl.sv
// ----------------------------------------------------------------------------
// fsmrs_ctl
// sequencer for schedule and dispatch transactions
// ----------------------------------------------------------------------------
module fsmrs_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  fsmrs_pkg::dp_sts_type   sts,
   output fsmrs_pkg::ctl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_RT_RD    = 8'b0000_0010,
      S_SCH_WR   = 8'b0000_0100,
      S_CHG_WR   = 8'b0000_1000,
      S_SCAN     = 8'b0001_0000,
      S_SCAN_END = 8'b0010_0000,
      S_OUT_RD   = 8'b0100_0000,
      S_OUT_RSP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_RT_RD;
         end
         S_RT_RD: begin
            state_in = sts.is_dispatch ? S_CHG_WR : S_SCH_WR;
         end
         S_SCH_WR:   state_in = S_IDLE;
         S_CHG_WR:   state_in = S_SCAN;
         S_SCAN: begin
            if (sts.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_OUT_RD;
         S_OUT_RD:   state_in = S_OUT_RSP;
         S_OUT_RSP:  state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign cmd.cap_req    = (state_ff == S_IDLE) && start;
   assign cmd.rt_rd      = (state_ff == S_RT_RD);
   assign cmd.sch_wr     = (state_ff == S_SCH_WR);
   assign cmd.chg_wr     = (state_ff == S_CHG_WR);
   assign cmd.scan_issue = (state_ff == S_SCAN);
   assign cmd.out_rd     = (state_ff == S_OUT_RD);
   assign cmd.out_rsp    = (state_ff == S_OUT_RSP);

endmodule

FILE: design/fsmrs_dp.sv
// ----------------------------------------------------------------------------
// fsmrs_dp
// runtime and key memories, ready flags, charge adder and minimum scan
// ----------------------------------------------------------------------------
module fsmrs_dp #(
   parameter int SLOTS = fsmrs_pkg::SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fsmrs_pkg::ctl_cmd_type  cmd,
   output fsmrs_pkg::dp_sts_type   sts,
   input  fsmrs_pkg::req_type      req_data,
   output logic                    rsp_strobe,
   output fsmrs_pkg::rsp_type      rsp_data
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int RT_W   = fsmrs_pkg::RUNTIME_W;
   localparam int T_W    = fsmrs_pkg::TIME_W;

   fsmrs_pkg::req_type req_ff;
   fsmrs_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_strobe_ff;

   logic [SLOT_W-1:0]  running_slot_ff;
   logic               running_vld_ff;
   logic [T_W-1:0]     last_time_ff;
   logic [SLOTS-1:0]   rt_vld_ff;
   logic [SLOTS-1:0]   ready_ff;
   logic               rt_rd_vld_ff;

   logic [SLOT_W-1:0]  cnt_ff;
   logic               pend_vld_ff;
   logic [SLOT_W-1:0]  pend_idx_ff;
   logic [SLOT_W-1:0]  best_idx_ff;
   logic [RT_W-1:0]    best_key_ff;
   logic               found_ff;

   logic [SLOT_W-1:0]  req_idx;
   logic               in_range;
   logic               rt_rd_en;
   logic [SLOT_W-1:0]  rt_rd_addr;
   logic [RT_W-1:0]    rt_rd_data;
   logic [RT_W-1:0]    rt_cur;
   logic               rt_wr_en;
   logic [RT_W-1:0]    rt_charged;
   logic [T_W-1:0]     elapsed;
   logic [T_W:0]       charge_sum;
   logic               key_wr_en;
   logic [RT_W-1:0]    key_rd_data;
   logic               take_key;

   assign req_idx  = SLOT_W'(req_ff.slot);
   assign in_range = (32'(req_ff.slot) < 32'(SLOTS));

   // runtime memory: read for schedule, charge and final report
   assign rt_rd_en = cmd.rt_rd || cmd.out_rd;
   always_comb begin
      priority if (cmd.out_rd) begin
         rt_rd_addr = best_idx_ff;
      end else if (req_ff.command == fsmrs_pkg::CMD_DISPATCH) begin
         rt_rd_addr = running_slot_ff;
      end else begin
         rt_rd_addr = req_idx;
      end
   end

   // never-written entries read as zero
   assign rt_cur = rt_rd_vld_ff ? rt_rd_data : '0;

   assign elapsed    = req_ff.now - last_time_ff;
   assign charge_sum = {2'b00, rt_cur} + {1'b0, elapsed};
   assign rt_charged = (charge_sum > {2'b00, fsmrs_pkg::RT_MAX}) ?
                       fsmrs_pkg::RT_MAX : charge_sum[RT_W-1:0];
   assign rt_wr_en   = cmd.chg_wr && running_vld_ff;

   fsmrs_ram #(
      .WIDTH (RT_W),
      .DEPTH (SLOTS)
   ) u_rt_ram (
      .clock   (clock),
      .wr_en   (rt_wr_en),
      .wr_addr (running_slot_ff),
      .wr_data (rt_charged),
      .rd_en   (rt_rd_en),
      .rd_addr (rt_rd_addr),
      .rd_data (rt_rd_data)
   );

   assign key_wr_en = cmd.sch_wr && in_range;

   fsmrs_ram #(
      .WIDTH (RT_W),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (req_idx),
      .wr_data (rt_cur),
      .rd_en   (cmd.scan_issue),
      .rd_addr (cnt_ff),
      .rd_data (key_rd_data)
   );

   // strict less-than keeps the lowest index on ties
   assign take_key = pend_vld_ff && ready_ff[pend_idx_ff] &&
                     (!found_ff || (key_rd_data < best_key_ff));

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.sch_wr) begin
         rsp_in.status         = fsmrs_pkg::STATUS_OK;
         rsp_in.chosen_slot    = req_ff.slot;
         rsp_in.chosen_runtime = in_range ? rt_cur : '0;
      end else if (cmd.out_rsp) begin
         if (found_ff) begin
            rsp_in.status         = fsmrs_pkg::STATUS_OK;
            rsp_in.chosen_slot    = fsmrs_pkg::SLOT_FIELD_W'(best_idx_ff);
            rsp_in.chosen_runtime = rt_cur;
         end else begin
            rsp_in.status         = fsmrs_pkg::STATUS_EMPTY;
            rsp_in.chosen_slot    = '0;
            rsp_in.chosen_runtime = '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         req_ff <= req_data;
      end
      if (rt_rd_en) begin
         rt_rd_vld_ff <= rt_vld_ff[rt_rd_addr];
      end
      if (cmd.chg_wr) begin
         cnt_ff <= '0;
      end else if (cmd.scan_issue) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      pend_idx_ff <= cnt_ff;
      if (take_key) begin
         best_idx_ff <= pend_idx_ff;
         best_key_ff <= key_rd_data;
      end
      rsp_ff <= rsp_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_slot_ff <= '0;
         running_vld_ff  <= 1'b0;
         last_time_ff    <= '0;
         rt_vld_ff       <= '0;
         ready_ff        <= '0;
         pend_vld_ff     <= 1'b0;
         found_ff        <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.sch_wr || cmd.out_rsp;
         pend_vld_ff   <= cmd.scan_issue;
         if (rt_wr_en) begin
            rt_vld_ff[running_slot_ff] <= 1'b1;
         end
         if (key_wr_en) begin
            ready_ff[req_idx] <= 1'b1;
         end
         if (cmd.chg_wr) begin
            last_time_ff <= req_ff.now;
            found_ff     <= 1'b0;
         end else if (take_key) begin
            found_ff <= 1'b1;
         end
         if (cmd.out_rsp) begin
            running_vld_ff <= found_ff;
            if (found_ff) begin
               running_slot_ff       <= best_idx_ff;
               ready_ff[best_idx_ff] <= 1'b0;
            end
         end
      end
   end

   assign sts.is_dispatch = (req_ff.command == fsmrs_pkg::CMD_DISPATCH);
   assign sts.scan_last   = (cnt_ff == SLOT_W'(SLOTS - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: design/fair_share_min_runtime_scheduler.sv
// ----------------------------------------------------------------------------
// fair_share_min_runtime_scheduler
// picks the ready slot with the smallest virtual runtime on each dispatch
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. After the
// accepting edge busy stays high while a schedule reads the slot's runtime
// and writes its key, and while a dispatch charges the running slot, scans
// the key memory for the minimum and reads the chosen runtime. A new one is
// taken only once busy is low again. The dispatch time is set by the minimum
// search, which reads one entry of the key memory per cycle. Each transaction
// gives exactly one result, shown on rsp_data for a single cycle with
// rsp_strobe high, in the first cycle that busy is low again. The receiver
// cannot stall it, so it must capture the result in that cycle. No clearing
// pass after reset: the block is ready in the first cycle out of reset.
`include "fair_share_min_runtime_scheduler_macros.svh"

module fair_share_min_runtime_scheduler #(
   parameter int SLOTS = fsmrs_pkg::SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fsmrs_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output fsmrs_pkg::rsp_type  rsp_data
);

   fsmrs_pkg::ctl_cmd_type cmd;
   fsmrs_pkg::dp_sts_type  sts;
   logic                   rsp_empty;
   logic                   rsp_zero;

   fsmrs_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   fsmrs_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign rsp_empty = rsp_strobe && (rsp_data.status == fsmrs_pkg::STATUS_EMPTY);
   assign rsp_zero  = (rsp_data.chosen_slot == '0) && (rsp_data.chosen_runtime == '0);

   `FSMRS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !rsp_strobe)
   `FSMRS_ASSERT_IMP(a_result_when_idle, rsp_strobe, !busy)
   `FSMRS_ASSERT_IMP(a_empty_gives_zero, rsp_empty, rsp_zero)

endmodule
